// File: hw/rtl/rbv_pkg.sv
// rbv_pkg: shared types, codes and widths for the rigid body velocity core.
// Used by the controller, the datapath and the top level.
package rbv_pkg;

    // Default accumulator sizing: log2 of the longest expected body in cells
    localparam int LOG_MAX_CELLS_DEF = 16;

    // Quotient cap of the long divider (2^40), and quotient register width
    localparam int QUOT_W = 42;
    localparam logic [QUOT_W-1:0] QUOT_CAP = QUOT_W'(64'd1 << 40);

    // Result status codes
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_ZERO_WEIGHT = 2'd1;
    localparam logic [1:0] STATUS_ZERO_INERT  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_STREAM_VX = 3'd2;
    localparam logic [2:0] REG_STREAM_VY = 3'd3;
    localparam logic [2:0] REG_CELL_AREA = 3'd4;

    // Divider operand selection
    localparam logic [1:0] DSEL_X   = 2'd0;
    localparam logic [1:0] DSEL_Y   = 2'd1;
    localparam logic [1:0] DSEL_ANG = 2'd2;

    // Multiplier steps of the area / inertia scaling
    localparam logic [1:0] MSTEP_AREA_LO = 2'd0;
    localparam logic [1:0] MSTEP_AREA_HI = 2'd1;
    localparam logic [1:0] MSTEP_INER_LO = 2'd2;
    localparam logic [1:0] MSTEP_INER_HI = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;     // capture input beat
        logic       stage_a;     // relative position products
        logic       stage_b;     // weighted products
        logic       accum;       // add into the sums
        logic       mul_en;      // area / inertia multiplier step
        logic [1:0] mul_step;
        logic       div_start;   // launch a division
        logic       div_store;   // keep the finished quotient
        logic [1:0] div_sel;
        logic       load_out;    // build result, clear sums
    } rbv_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
        logic last;
    } rbv_sts_t;

endpackage

// File: hw/rtl/rigid_body_velocity_from_moments_core.sv
// rigid_body_velocity_from_moments_core: top level, controller plus datapath.
// Uses rbv_pkg, rbv_ctrl, rbv_datapath.
//
// Reduces the grid cells of one body to its area, inertia, translational and
// angular velocity (all Q.16). Each cell beat steps through capture, the
// position products, the weighted products and the accumulate; the two
// product steps each go through one registered multiply stage. On the beat
// with tlast the block then runs the area/inertia scaling on one shared 32x32
// multiplier and three bit-serial divisions, each launched in turn, and then
// loads the result register once it is free or being taken. The result
// register lets the next body start while the result waits.
module rigid_body_velocity_from_moments_core
    import rbv_pkg::*;
#(
    parameter int LOG_MAX_CELLS = LOG_MAX_CELLS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // weight[16:0], fluid_u[40:17], fluid_v[64:41], cell_x[88:65], cell_y[112:89]
    input  logic [119:0] s_tdata,
    input  logic         s_tlast,    // final_cell
    input  logic         s_tvalid,
    output logic         s_tready,
    // body_area[32:0], body_inertia[82:33], body_vel_x[114:83],
    // body_vel_y[146:115], body_ang_vel[178:147]
    output logic [183:0] m_tdata,
    output logic [1:0]   m_tuser,    // status
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    rbv_cmd_t cmd;
    rbv_sts_t sts;

    rbv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rbv_datapath #(
        .LOG_MAX_CELLS (LOG_MAX_CELLS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );
endmodule

// File: hw/rtl/rbv_div.sv
// rbv_div: iterative restoring divider, one quotient bit per cycle,
// computes (num << 16) / den with the quotient capped. Uses rbv_pkg.
module rbv_div
    import rbv_pkg::*;
#(
    parameter int NUM_W = 53,
    parameter int DEN_W = 52
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic [QUOT_W-1:0] quot,
    output logic              done
);
    localparam int STEPS = NUM_W + 16;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0] q_reg, q_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;
    logic              ge;
    logic [QUOT_W-1:0] q_shift;

    // One long division step
    always_comb begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        ge       = (trial >= {1'b0, den});
        q_shift  = {q_reg[QUOT_W-2:0], ge};
        num_next = num_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            num_next = num;
            rem_next = '0;
            q_next   = '0;
            cnt_next = CNT_W'(STEPS);
        end else if (cnt_reg != '0) begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            rem_next = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            q_next   = (q_shift > QUOT_CAP) ? QUOT_CAP : q_shift;
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;
endmodule

// File: hw/rtl/rbv_datapath.sv
// rbv_datapath: input capture, per-cell products, accumulators, scaling
// multiplier, quotient handling and output register. Uses rbv_pkg, rbv_div.
module rbv_datapath
    import rbv_pkg::*;
#(
    parameter int LOG_MAX_CELLS = LOG_MAX_CELLS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  rbv_cmd_t       cmd,
    output rbv_sts_t       sts,
    input  logic [119:0]   in_data,
    input  logic           in_last,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output logic [183:0]   out_data,
    output logic [1:0]     out_status
);
    localparam int W_SW  = 18 + LOG_MAX_CELLS;
    localparam int W_MOM = 26 + LOG_MAX_CELLS;
    localparam int W_ANG = 37 + LOG_MAX_CELLS;
    localparam int W_RSQ = 36 + LOG_MAX_CELLS;

    // Configuration
    logic signed [23:0] center_x_reg, center_y_reg, stream_vx_reg, stream_vy_reg;
    logic [31:0]        cell_area_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            stream_vx_reg <= '0;
            stream_vy_reg <= '0;
            cell_area_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CENTER_X:  center_x_reg  <= cfg_data[23:0];
                REG_CENTER_Y:  center_y_reg  <= cfg_data[23:0];
                REG_STREAM_VX: stream_vx_reg <= cfg_data[23:0];
                REG_STREAM_VY: stream_vy_reg <= cfg_data[23:0];
                REG_CELL_AREA: cell_area_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input capture
    logic [16:0]        w_reg;
    logic signed [23:0] u_reg, v_reg, x_reg, y_reg;
    logic               last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            w_reg    <= in_data[16:0];
            u_reg    <= in_data[40:17];
            v_reg    <= in_data[64:41];
            x_reg    <= in_data[88:65];
            y_reg    <= in_data[112:89];
            last_reg <= in_last;
        end
    end

    // Stage A: relative position, angular and radius terms
    logic signed [24:0] dx, dy;
    logic signed [48:0] p_dxv, p_dyu;
    logic signed [49:0] p_dxx, p_dyy;
    logic signed [33:0] ang_next, ang_reg;
    logic [33:0]        rsq_next, rsq_reg;

    always_comb begin
        dx    = 25'(x_reg) - 25'(center_x_reg);
        dy    = 25'(y_reg) - 25'(center_y_reg);
        p_dxv = dx * 49'(v_reg);
        p_dyu = dy * 49'(u_reg);
        p_dxx = dx * dx;
        p_dyy = dy * dy;
        ang_next = 34'($signed(p_dxv[48:16])) - 34'($signed(p_dyu[48:16]));
        rsq_next = 34'(p_dxx[48:16]) + 34'(p_dyy[48:16]);
    end

    always_ff @(posedge aclk) begin
        if (cmd.stage_a) begin
            ang_reg <= ang_next;
            rsq_reg <= rsq_next;
        end
    end

    // Stage B: weighted terms, floored to 16 fraction bits
    logic signed [17:0] ws;
    logic signed [41:0] p_wu, p_wv;
    logic signed [51:0] p_wa;
    logic [50:0]        p_wr;
    logic signed [25:0] t_mx_reg, t_my_reg;
    logic signed [35:0] t_ang_reg;
    logic [34:0]        t_rsq_reg;

    always_comb begin
        ws   = {1'b0, w_reg};
        p_wu = 42'(ws) * 42'(u_reg);
        p_wv = 42'(ws) * 42'(v_reg);
        p_wa = 52'(ws) * 52'(ang_reg);
        p_wr = 51'(w_reg) * 51'(rsq_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.stage_b) begin
            t_mx_reg  <= p_wu[41:16];
            t_my_reg  <= p_wv[41:16];
            t_ang_reg <= p_wa[51:16];
            t_rsq_reg <= p_wr[50:16];
        end
    end

    // Accumulators, wrapping at their widths
    logic [W_SW-1:0]  sw_reg;
    logic [W_MOM-1:0] smx_reg, smy_reg;
    logic [W_ANG-1:0] sang_reg;
    logic [W_RSQ-1:0] srsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load_out) begin
            sw_reg   <= '0;
            smx_reg  <= '0;
            smy_reg  <= '0;
            sang_reg <= '0;
            srsq_reg <= '0;
        end else if (cmd.accum) begin
            sw_reg   <= sw_reg + W_SW'(w_reg);
            smx_reg  <= smx_reg + W_MOM'(t_mx_reg);
            smy_reg  <= smy_reg + W_MOM'(t_my_reg);
            sang_reg <= sang_reg + W_ANG'(t_ang_reg);
            srsq_reg <= srsq_reg + W_RSQ'(t_rsq_reg);
        end
    end

    // Area / inertia scaling: one 32x32 multiplier over four steps
    logic [63:0]  sw_ext, srsq_ext;
    logic [31:0]  mul_a;
    logic [63:0]  mul_p, plo_reg;
    logic [64:0]  scaled;
    logic [32:0]  area_reg;
    logic [49:0]  inertia_reg;

    always_comb begin
        sw_ext   = 64'(sw_reg);
        srsq_ext = 64'(srsq_reg);
        unique case (cmd.mul_step)
            MSTEP_AREA_LO: mul_a = sw_ext[31:0];
            MSTEP_AREA_HI: mul_a = sw_ext[63:32];
            MSTEP_INER_LO: mul_a = srsq_ext[31:0];
            MSTEP_INER_HI: mul_a = srsq_ext[63:32];
            default:       mul_a = '0;
        endcase
        mul_p  = 64'(mul_a) * 64'(cell_area_reg);
        scaled = 65'(mul_p) + 65'(plo_reg[63:32]);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            unique case (cmd.mul_step)
                MSTEP_AREA_LO, MSTEP_INER_LO: plo_reg <= mul_p;
                MSTEP_AREA_HI:
                    area_reg <= (scaled > 65'(64'd1 << 32)) ? 33'(64'd1 << 32) : scaled[32:0];
                MSTEP_INER_HI:
                    inertia_reg <= (scaled > 65'((64'd1 << 50) - 1)) ? '1 : scaled[49:0];
                default: ;
            endcase
        end
    end

    // Divider operands: magnitude of the numerator, sign kept aside
    logic [W_ANG-1:0] div_num;
    logic [W_RSQ-1:0] div_den;
    logic             div_neg;
    logic [QUOT_W-1:0] div_q;
    logic             div_done;

    always_comb begin
        unique case (cmd.div_sel)
            DSEL_X: begin
                div_neg = smx_reg[W_MOM-1];
                div_num = W_ANG'(div_neg ? W_MOM'(-smx_reg) : smx_reg);
                div_den = W_RSQ'(sw_reg);
            end
            DSEL_Y: begin
                div_neg = smy_reg[W_MOM-1];
                div_num = W_ANG'(div_neg ? W_MOM'(-smy_reg) : smy_reg);
                div_den = W_RSQ'(sw_reg);
            end
            default: begin
                div_neg = sang_reg[W_ANG-1];
                div_num = div_neg ? W_ANG'(-sang_reg) : sang_reg;
                div_den = srsq_reg;
            end
        endcase
    end

    rbv_div #(
        .NUM_W (W_ANG),
        .DEN_W (W_RSQ)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_q),
        .done    (div_done)
    );

    // Signed quotients
    logic signed [QUOT_W:0] qs;
    logic signed [QUOT_W:0] qx_reg, qy_reg, qa_reg;

    assign qs = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            unique case (cmd.div_sel)
                DSEL_X:  qx_reg <= qs;
                DSEL_Y:  qy_reg <= qs;
                default: qa_reg <= qs;
            endcase
        end
    end

    // Result assembly with saturation
    function automatic logic [31:0] sat32(input logic signed [QUOT_W+1:0] x);
        logic [31:0] r;
        if (x > (QUOT_W+2)'(64'sd2147483647))
            r = 32'h7FFF_FFFF;
        else if (x < -(QUOT_W+2)'(64'sd2147483648))
            r = 32'h8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    logic               zero_w, zero_r;
    logic signed [QUOT_W+1:0] vx, vy, om;
    logic [1:0]         status;

    always_comb begin
        zero_w = (sw_reg == '0);
        zero_r = (srsq_reg == '0);
        vx = (QUOT_W+2)'(stream_vx_reg) + (zero_w ? '0 : (QUOT_W+2)'(qx_reg));
        vy = (QUOT_W+2)'(stream_vy_reg) + (zero_w ? '0 : (QUOT_W+2)'(qy_reg));
        om = zero_r ? '0 : (QUOT_W+2)'(qa_reg);
        priority if (zero_w)
            status = STATUS_ZERO_WEIGHT;
        else if (zero_r)
            status = STATUS_ZERO_INERT;
        else
            status = STATUS_OK;
    end

    logic [183:0] out_data_reg;
    logic [1:0]   out_status_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg   <= {5'd0, sat32(om), sat32(vy), sat32(vx),
                               inertia_reg, area_reg};
            out_status_reg <= status;
        end
    end

    assign out_data     = out_data_reg;
    assign out_status   = out_status_reg;
    assign sts.div_done = div_done;
    assign sts.last     = last_reg;
endmodule

// File: hw/rtl/rbv_ctrl.sv
// rbv_ctrl: controller state machine sequencing the per-cell stages, the
// scaling steps, three divisions and the output handshake. Uses rbv_pkg.
module rbv_ctrl
    import rbv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output rbv_cmd_t cmd,
    input  rbv_sts_t sts
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MULA  = 4'd1;
    localparam logic [3:0] ST_MULB  = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_AR_LO = 4'd4;
    localparam logic [3:0] ST_AR_HI = 4'd5;
    localparam logic [3:0] ST_IN_LO = 4'd6;
    localparam logic [3:0] ST_IN_HI = 4'd7;
    localparam logic [3:0] ST_DIV_GO  = 4'd8;
    localparam logic [3:0] ST_DIV_RUN = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       mvalid_reg, mvalid_next;

    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        cmd.div_sel = sel_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_tvalid;
                if (s_tvalid) state_next = ST_MULA;
            end
            ST_MULA: begin
                cmd.stage_a = 1'b1;
                state_next  = ST_MULB;
            end
            ST_MULB: begin
                cmd.stage_b = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.accum  = 1'b1;
                state_next = sts.last ? ST_AR_LO : ST_IDLE;
            end
            ST_AR_LO: begin
                cmd.mul_en = 1'b1; cmd.mul_step = MSTEP_AREA_LO;
                state_next = ST_AR_HI;
            end
            ST_AR_HI: begin
                cmd.mul_en = 1'b1; cmd.mul_step = MSTEP_AREA_HI;
                state_next = ST_IN_LO;
            end
            ST_IN_LO: begin
                cmd.mul_en = 1'b1; cmd.mul_step = MSTEP_INER_LO;
                state_next = ST_IN_HI;
            end
            ST_IN_HI: begin
                cmd.mul_en = 1'b1; cmd.mul_step = MSTEP_INER_HI;
                sel_next   = DSEL_X;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (sts.div_done) begin
                    cmd.div_store = 1'b1;
                    if (sel_reg == DSEL_ANG) begin
                        state_next = ST_OUT;
                    end else begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_OUT: begin
                // output register free, or being taken this cycle
                if (!mvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sel_reg    <= DSEL_X;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
endmodule

// File: hw/rtl/rbv_checker.sv
// rbv_checker: port-level assertions for the rigid body velocity core,
// bound to the top level. Uses rbv_pkg.
module rbv_checker
    import rbv_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [183:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tvalid,
    input logic         m_tready
);
    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // one cell at a time: busy right after a cell is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a cell is in flight");

    // zero inertia gives zero angular velocity
    a_zero_om: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_ZERO_INERT |-> m_tdata[178:147] == '0)
        else $error("angular velocity nonzero with zero inertia");

    // status codes and the area limit
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3 && (!m_tdata[32] || m_tdata[31:0] == '0))
        else $error("status or area out of range");
endmodule

bind rigid_body_velocity_from_moments_core rbv_checker u_rbv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// File: verif/tb_rigid_body_velocity_from_moments_core.sv
// Testbench for rigid_body_velocity_from_moments_core: streams grid cells of
// bodies, predicts area, inertia and velocities, and checks every result beat.
// Depends on rbv_pkg and the core RTL only.
module tb_rigid_body_velocity_from_moments_core
    import rbv_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOGC = LOG_MAX_CELLS_DEF;
    localparam int W_WT  = 18 + LOGC;
    localparam int W_MOM = 26 + LOGC;
    localparam int W_ANG = 37 + LOGC;
    localparam int W_RSQ = 36 + LOGC;
    localparam int DRAIN_CYCLES = 3 * LOGC + 200;

    typedef struct packed {
        logic [32:0] area;
        logic [49:0] inertia;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] ang_vel;
        logic [1:0]  status;
    } body_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [119:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [183:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    rigid_body_velocity_from_moments_core dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    // Predictor state: configuration copy and running sums
    longint ctr_x, ctr_y, strm_x, strm_y;
    longint unsigned area_scale;
    longint unsigned tot_wt, tot_mx, tot_my, tot_ang, tot_rsq;
    body_result_t expected_bodies[$];
    int  errors = 0;
    bit  rx_no_stall = 0;
    bit  tx_no_stall = 0;

    function automatic longint sx24(logic [23:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint sxw(longint unsigned v, int w);
        longint unsigned m;
        m = (64'd1 << w) - 1;
        v &= m;
        if (v[w-1]) return -longint'(((~v) + 1) & m);
        return longint'(v);
    endfunction

    // floor(x / 2^16)
    function automatic longint fl16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint unsigned scale_q32(longint unsigned a, longint unsigned b);
        return (a >> 32) * b + (((a & 64'hFFFF_FFFF) * b) >> 32);
    endfunction

    // (num << 16) / den restoring division with the quotient cap
    function automatic longint unsigned quot_q16(longint unsigned num, longint unsigned den);
        longint unsigned rem, q, b;
        rem = 0;
        q = 0;
        for (int i = 79; i >= 0; i--) begin
            b = (i >= 16) ? ((num >> (i - 16)) & 1) : 0;
            rem = (rem << 1) | b;
            q <<= 1;
            if (rem >= den) begin
                rem -= den;
                q |= 1;
            end
            if (q > (64'd1 << 40)) q = 64'd1 << 40;
        end
        return q;
    endfunction

    function automatic longint sgn_quot(longint num, longint unsigned den);
        longint q;
        q = longint'(quot_q16((num < 0) ? longint'(-num) : num, den));
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic [31:0] clip32(longint x);
        if (x > 64'sd2147483647) x = 64'sd2147483647;
        if (x < -64'sd2147483648) x = -64'sd2147483648;
        return x[31:0];
    endfunction

    function automatic void clear_totals();
        tot_wt = 0; tot_mx = 0; tot_my = 0; tot_ang = 0; tot_rsq = 0;
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_CENTER_X:  ctr_x = sx24(val[23:0]);
            REG_CENTER_Y:  ctr_y = sx24(val[23:0]);
            REG_STREAM_VX: strm_x = sx24(val[23:0]);
            REG_STREAM_VY: strm_y = sx24(val[23:0]);
            REG_CELL_AREA: area_scale = 64'(val);
            default: ;
        endcase
    endfunction

    // Fold one cell into the sums; on the final cell queue the body result
    function automatic void accumulate_cell(logic [16:0] wt, logic [23:0] fu, logic [23:0] fv,
                                            logic [23:0] px, logic [23:0] py, logic fin);
        longint w, u, v, dx, dy, ang, rsq, tw, mx, my, ta, vx, vy, om;
        longint unsigned tr, ar, in;
        body_result_t r;
        w = longint'(wt); u = sx24(fu); v = sx24(fv);
        dx = sx24(px) - ctr_x;
        dy = sx24(py) - ctr_y;
        ang = fl16(dx * v) - fl16(dy * u);
        rsq = fl16(dx * dx) + fl16(dy * dy);
        tot_wt  = (tot_wt + w) & ((64'd1 << W_WT) - 1);
        tot_mx  = (tot_mx + fl16(w * u)) & ((64'd1 << W_MOM) - 1);
        tot_my  = (tot_my + fl16(w * v)) & ((64'd1 << W_MOM) - 1);
        tot_ang = (tot_ang + fl16(w * ang)) & ((64'd1 << W_ANG) - 1);
        tot_rsq = (tot_rsq + fl16(w * rsq)) & ((64'd1 << W_RSQ) - 1);
        if (!fin) return;
        tw = tot_wt;
        mx = sxw(tot_mx, W_MOM);
        my = sxw(tot_my, W_MOM);
        ta = sxw(tot_ang, W_ANG);
        tr = tot_rsq;
        ar = scale_q32(tw, area_scale);
        if (ar > (64'd1 << 32)) ar = 64'd1 << 32;
        in = scale_q32(tr, area_scale);
        if (in > ((64'd1 << 50) - 1)) in = (64'd1 << 50) - 1;
        vx = strm_x; vy = strm_y;
        r.status = STATUS_OK;
        if (tw == 0) r.status = STATUS_ZERO_WEIGHT;
        else begin
            vx += sgn_quot(mx, tw);
            vy += sgn_quot(my, tw);
        end
        om = 0;
        if (tr == 0) begin
            if (r.status == STATUS_OK) r.status = STATUS_ZERO_INERT;
        end else om = sgn_quot(ta, tr);
        r.area = 33'(ar);
        r.inertia = 50'(in);
        r.vel_x = clip32(vx);
        r.vel_y = clip32(vy);
        r.ang_vel = clip32(om);
        expected_bodies = {expected_bodies, r};
        clear_totals();
    endfunction

    // Result checker with random back-pressure
    always @(posedge aclk) begin
        body_result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got.area    = m_tdata[32:0];
            got.inertia = m_tdata[82:33];
            got.vel_x   = m_tdata[114:83];
            got.vel_y   = m_tdata[146:115];
            got.ang_vel = m_tdata[178:147];
            got.status  = m_tuser;
            if (expected_bodies.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
            end else begin
                exp_r = expected_bodies.pop_front();
                if (got.area !== exp_r.area) begin
                    errors++;
                    $display("%0t: area exp %h got %h", $time, exp_r.area, got.area);
                end
                if (got.inertia !== exp_r.inertia) begin
                    errors++;
                    $display("%0t: inertia exp %h got %h", $time, exp_r.inertia, got.inertia);
                end
                if (got.vel_x !== exp_r.vel_x) begin
                    errors++;
                    $display("%0t: vel_x exp %h got %h", $time, exp_r.vel_x, got.vel_x);
                end
                if (got.vel_y !== exp_r.vel_y) begin
                    errors++;
                    $display("%0t: vel_y exp %h got %h", $time, exp_r.vel_y, got.vel_y);
                end
                if (got.ang_vel !== exp_r.ang_vel) begin
                    errors++;
                    $display("%0t: ang_vel exp %h got %h", $time, exp_r.ang_vel, got.ang_vel);
                end
                if (got.status !== exp_r.status) begin
                    errors++;
                    $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                end
            end
        end
        m_tready <= rx_no_stall || ($urandom_range(99) >= 30);
    end

    // One register write; the write enable is dropped again before the task returns
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        apply_cfg(idx, val);
        @(posedge aclk);
    endtask

    // Send one cell beat, with random gaps before it unless tx_no_stall is set; tvalid
    // is left high after the beat and dropped by the next gap or by wait_idle
    task automatic send_cell(logic [16:0] wt, logic [23:0] fu, logic [23:0] fv,
                             logic [23:0] px, logic [23:0] py, logic fin);
        while (!tx_no_stall && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= {7'd0, py, px, fv, fu, wt};
        s_tlast <= fin;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        accumulate_cell(wt, fu, fv, px, py, fin);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (expected_bodies.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [23:0] rnd24(int mode);
        case (mode)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(2048) - 1024) << 8;
            default: return 24'($urandom);
        endcase
    endfunction

    // Random body: random weights and fields, with extremes mixed in
    task automatic send_body(int ncells);
        logic [16:0] wt;
        for (int i = 0; i < ncells; i++) begin
            case ($urandom_range(9))
                0: wt = 17'd0;
                1: wt = 17'd65536;
                2: wt = 17'h1FFFF;
                default: wt = 17'($urandom_range(65536));
            endcase
            send_cell(wt, rnd24($urandom_range(6)), rnd24($urandom_range(6)),
                      rnd24($urandom_range(6)), rnd24($urandom_range(6)), i == ncells - 1);
        end
    endtask

    task automatic test_directed();
        write_reg(REG_CELL_AREA, 32'h0100_0000);
        // zero total weight: velocity equals free stream
        send_cell(17'd0, 24'h7FFFFF, 24'h800000, 24'h010000, 24'h020000, 1'b1);
        // zero inertia: cell sits on the centre
        send_cell(17'd65536, 24'h010000, 24'hFF0000, 24'h000000, 24'h000000, 1'b1);
        // extremes of every field, oversized weight
        send_cell(17'h1FFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 1'b0);
        send_cell(17'h1FFFF, 24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 1'b1);
        // tiny weight against huge momentum
        send_cell(17'd1, 24'h7FFFFF, 24'h800000, 24'h000100, 24'h000000, 1'b1);
        send_cell(17'd32768, 24'h123456, 24'hABCDEF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_cell(17'd65536, 24'h000001, 24'hFFFFFF, 24'h800000, 24'h800000, 1'b1);
        wait_idle();
    endtask

    task automatic test_config_sweep();
        logic [31:0] pick;
        for (int ph = 0; ph < 6; ph++) begin
            for (int r = 0; r < 5; r++) begin
                case (ph)
                    0: pick = 32'h0;
                    1: pick = (r == 4) ? 32'hFFFF_FFFF : 32'h007F_FFFF;
                    2: pick = (r == 4) ? 32'h0000_0001 : 32'h0080_0000;
                    default: pick = $urandom;
                endcase
                if (r < 4) pick = {8'd0, pick[23:0]};
                write_reg(3'(r), pick);
            end
            for (int b = 0; b < 25; b++) send_body($urandom_range(1, 8));
            wait_idle();
        end
    endtask

    task automatic test_random_stream();
        write_reg(REG_CELL_AREA, $urandom);
        tx_no_stall = 1;
        rx_no_stall = 1;
        for (int b = 0; b < 40; b++) send_body($urandom_range(1, 6));
        tx_no_stall = 0;
        rx_no_stall = 0;
        wait_idle();
        for (int b = 0; b < 90; b++) send_body($urandom_range(1, 10));
    endtask

    // A long body exercises accumulator growth
    task automatic test_long_body();
        wait_idle();
        write_reg(REG_CELL_AREA, 32'hFFFF_FFFF);
        send_body(200);
    endtask

    initial begin
        ctr_x = 0; ctr_y = 0; strm_x = 0; strm_y = 0; area_scale = 0;
        clear_totals();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_sweep();
        test_random_stream();
        test_long_body();
        wait_idle();
        if (errors == 0 && expected_bodies.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
